FILE: rtl/core/tsc_pkg.sv
package tsc_pkg;

  // series and format limits
  localparam int FRAC_BITS = 28;
  localparam int MAX_TERMS = 11;
  localparam int ANGLE_W   = 32;
  localparam int VALUE_W   = 48;
  localparam int STATUS_W  = 2;
  localparam int MODE_W    = 2;
  localparam int COUNT_W   = 4;

  // internal widths (magnitudes stay far below these for |angle| < 8)
  localparam int X2_W     = 36;
  localparam int TERM_W   = 40;
  localparam int SUM_W    = 48;
  localparam int RECIP_W  = 28;
  localparam int SPLIT_T  = TERM_W / 2;
  localparam int MID_W    = 48;
  localparam int SPLIT_M  = MID_W / 2;
  localparam int PP_W     = SPLIT_T + X2_W;
  localparam int PC_W     = SPLIT_M + RECIP_W;
  localparam int FULL_W   = TERM_W + X2_W;
  localparam int FULL2_W  = MID_W + RECIP_W;

  // tangent divider
  localparam int MAG_W = SUM_W;
  localparam int QB    = VALUE_W + 1;
  localparam int SHIFT = QB - FRAC_BITS;

  localparam logic [COUNT_W-1:0] TERM_COUNT_RESET = COUNT_W'(MAX_TERMS);
  localparam logic [63:0]        ONE  = 64'd1 << FRAC_BITS;
  localparam logic [63:0]        HALF = 64'd1 << (FRAC_BITS - 1);

  // mode and status codes
  localparam logic [MODE_W-1:0]   MODE_COS     = 2'd0;
  localparam logic [MODE_W-1:0]   MODE_SIN     = 2'd1;
  localparam logic [MODE_W-1:0]   MODE_TAN     = 2'd2;
  localparam logic [MODE_W-1:0]   MODE_TAN_ALT = 2'd3;
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SAT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CZERO  = 2'd2;

  localparam int LANE_COS = 0;
  localparam int LANE_SIN = 1;

  localparam logic [VALUE_W-1:0] OUT_POS_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] OUT_NEG_MAX = {1'b1, {(VALUE_W-1){1'b0}}};

  // rounded reciprocals of (k-1)k, indexed by step i; cosine k = 2i, sine k = 2i+1
  localparam logic [RECIP_W-1:0] RECIP_COS [MAX_TERMS] = '{
    '0,
    RECIP_W'((ONE + 64'd1)   / 64'd2),
    RECIP_W'((ONE + 64'd6)   / 64'd12),
    RECIP_W'((ONE + 64'd15)  / 64'd30),
    RECIP_W'((ONE + 64'd28)  / 64'd56),
    RECIP_W'((ONE + 64'd45)  / 64'd90),
    RECIP_W'((ONE + 64'd66)  / 64'd132),
    RECIP_W'((ONE + 64'd91)  / 64'd182),
    RECIP_W'((ONE + 64'd120) / 64'd240),
    RECIP_W'((ONE + 64'd153) / 64'd306),
    RECIP_W'((ONE + 64'd190) / 64'd380)
  };
  localparam logic [RECIP_W-1:0] RECIP_SIN [MAX_TERMS] = '{
    '0,
    RECIP_W'((ONE + 64'd3)   / 64'd6),
    RECIP_W'((ONE + 64'd10)  / 64'd20),
    RECIP_W'((ONE + 64'd21)  / 64'd42),
    RECIP_W'((ONE + 64'd36)  / 64'd72),
    RECIP_W'((ONE + 64'd55)  / 64'd110),
    RECIP_W'((ONE + 64'd78)  / 64'd156),
    RECIP_W'((ONE + 64'd105) / 64'd210),
    RECIP_W'((ONE + 64'd136) / 64'd272),
    RECIP_W'((ONE + 64'd171) / 64'd342),
    RECIP_W'((ONE + 64'd210) / 64'd420)
  };

  // one series lane: current term as sign and magnitude, running sum
  typedef struct packed {
    logic              neg;
    logic [TERM_W-1:0] mag;
    logic [SUM_W-1:0]  sum;
  } lane_t;

  // word traveling down the term pipeline
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [COUNT_W-1:0] n;
    logic [X2_W-1:0]    x2;
    lane_t [1:0]        ln;
  } item_t;

  function automatic logic [RECIP_W-1:0] recip(input logic sin_lane,
                                               input logic [COUNT_W-1:0] step);
    return sin_lane ? RECIP_SIN[step] : RECIP_COS[step];
  endfunction

  function automatic logic [SUM_W-1:0] term_val(input lane_t l);
    logic [SUM_W-1:0] t;
    t = SUM_W'(l.mag);
    return l.neg ? SUM_W'(0) - t : t;
  endfunction

endpackage

FILE: rtl/core/tsc_square.sv
module tsc_square (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [tsc_pkg::MODE_W-1:0]    mode,
  input  logic [tsc_pkg::ANGLE_W-1:0]   angle,
  input  logic [tsc_pkg::COUNT_W-1:0]   term_count,
  output logic                          out_valid,
  output tsc_pkg::item_t                out_item
);

  logic                            v1, v2;
  logic [tsc_pkg::MODE_W-1:0]      mode1, mode2;
  logic [tsc_pkg::COUNT_W-1:0]     n1, n2;
  logic                            xneg1, xneg2;
  logic [tsc_pkg::ANGLE_W-1:0]     xm1, xm2;
  logic [2*tsc_pkg::ANGLE_W-1:0]   sq2;
  logic [2*tsc_pkg::ANGLE_W-1:0]   sq_round;
  tsc_pkg::item_t                  out_item_next;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  // stage 1: magnitude and clamped term count
  always_ff @(posedge clk) begin
    if (en) begin
      mode1 <= mode;
      n1    <= (term_count > tsc_pkg::COUNT_W'(tsc_pkg::MAX_TERMS)) ?
               tsc_pkg::COUNT_W'(tsc_pkg::MAX_TERMS) : term_count;
      xneg1 <= angle[tsc_pkg::ANGLE_W-1];
      xm1   <= angle[tsc_pkg::ANGLE_W-1] ? tsc_pkg::ANGLE_W'(0) - angle : angle;
    end
  end

  // stage 2: square of the magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      mode2 <= mode1;
      n2    <= n1;
      xneg2 <= xneg1;
      xm2   <= xm1;
      sq2   <= (2*tsc_pkg::ANGLE_W)'(xm1) * (2*tsc_pkg::ANGLE_W)'(xm1);
    end
  end

  // stage 3: round the square, seed both series
  always_comb begin
    sq_round = sq2 + tsc_pkg::HALF;
    out_item_next = '0;
    out_item_next.mode = mode2;
    out_item_next.n    = n2;
    out_item_next.x2   = sq_round[tsc_pkg::FRAC_BITS +: tsc_pkg::X2_W];
    out_item_next.ln[tsc_pkg::LANE_COS].neg = 1'b0;
    out_item_next.ln[tsc_pkg::LANE_COS].mag = tsc_pkg::TERM_W'(tsc_pkg::ONE);
    out_item_next.ln[tsc_pkg::LANE_COS].sum = '0;
    out_item_next.ln[tsc_pkg::LANE_SIN].neg = xneg2;
    out_item_next.ln[tsc_pkg::LANE_SIN].mag = tsc_pkg::TERM_W'(xm2);
    out_item_next.ln[tsc_pkg::LANE_SIN].sum = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= out_item_next;
    end
  end

endmodule

FILE: rtl/core/tsc_step.sv
module tsc_step (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic [tsc_pkg::COUNT_W-1:0]  step,
  input  logic                         in_valid,
  input  tsc_pkg::item_t               in_item,
  output logic                         out_valid,
  output tsc_pkg::item_t               out_item
);

  logic                         va, vb, vc;
  tsc_pkg::item_t               item_a, item_b, item_c;
  tsc_pkg::item_t               item_a_next, out_item_next;
  logic [tsc_pkg::PP_W-1:0]     pp_lo [2];
  logic [tsc_pkg::PP_W-1:0]     pp_hi [2];
  logic [tsc_pkg::PP_W-1:0]     pp_lo_next [2];
  logic [tsc_pkg::PP_W-1:0]     pp_hi_next [2];
  logic [tsc_pkg::MID_W-1:0]    mid [2];
  logic [tsc_pkg::MID_W-1:0]    mid_next [2];
  logic [tsc_pkg::PC_W-1:0]     pc_lo [2];
  logic [tsc_pkg::PC_W-1:0]     pc_hi [2];
  logic [tsc_pkg::PC_W-1:0]     pc_lo_next [2];
  logic [tsc_pkg::PC_W-1:0]     pc_hi_next [2];
  logic [tsc_pkg::FULL_W-1:0]   full [2];
  logic [tsc_pkg::FULL2_W-1:0]  full2 [2];
  logic                         take;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
      out_valid <= vc;
    end
  end

  // stage a: fold the previous term into the sum if it is within the term count, term times x^2 in two halves
  always_comb begin
    take = (step - tsc_pkg::COUNT_W'(1)) < in_item.n;
    item_a_next = in_item;
    for (int l = 0; l < 2; l++) begin
      if (take) begin
        item_a_next.ln[l].sum = in_item.ln[l].sum + tsc_pkg::term_val(in_item.ln[l]);
      end
      pp_lo_next[l] = tsc_pkg::PP_W'(in_item.ln[l].mag[tsc_pkg::SPLIT_T-1:0]) *
                      tsc_pkg::PP_W'(in_item.x2);
      pp_hi_next[l] = tsc_pkg::PP_W'(in_item.ln[l].mag[tsc_pkg::TERM_W-1:tsc_pkg::SPLIT_T]) *
                      tsc_pkg::PP_W'(in_item.x2);
    end
  end

  // stage b: join halves and round
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      full[l] = {pp_hi[l], {tsc_pkg::SPLIT_T{1'b0}}} + tsc_pkg::FULL_W'(pp_lo[l]) +
                tsc_pkg::FULL_W'(tsc_pkg::HALF);
      mid_next[l] = full[l][tsc_pkg::FRAC_BITS +: tsc_pkg::MID_W];
    end
  end

  // stage c: times the reciprocal in two halves
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      pc_lo_next[l] = tsc_pkg::PC_W'(mid[l][tsc_pkg::SPLIT_M-1:0]) *
                      tsc_pkg::PC_W'(tsc_pkg::recip(1'(l), step));
      pc_hi_next[l] = tsc_pkg::PC_W'(mid[l][tsc_pkg::MID_W-1:tsc_pkg::SPLIT_M]) *
                      tsc_pkg::PC_W'(tsc_pkg::recip(1'(l), step));
    end
  end

  // stage d: join, round, negate to form the next term
  always_comb begin
    out_item_next = item_c;
    for (int l = 0; l < 2; l++) begin
      full2[l] = {pc_hi[l], {tsc_pkg::SPLIT_M{1'b0}}} + tsc_pkg::FULL2_W'(pc_lo[l]) +
                 tsc_pkg::FULL2_W'(tsc_pkg::HALF);
      out_item_next.ln[l].mag = full2[l][tsc_pkg::FRAC_BITS +: tsc_pkg::TERM_W];
      out_item_next.ln[l].neg = ~item_c.ln[l].neg;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_a   <= item_a_next;
      item_b   <= item_a;
      item_c   <= item_b;
      out_item <= out_item_next;
      for (int l = 0; l < 2; l++) begin
        pp_lo[l] <= pp_lo_next[l];
        pp_hi[l] <= pp_hi_next[l];
        mid[l]   <= mid_next[l];
        pc_lo[l] <= pc_lo_next[l];
        pc_hi[l] <= pc_hi_next[l];
      end
    end
  end

endmodule

FILE: rtl/core/tsc_divider.sv
module tsc_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  tsc_pkg::item_t                in_item,
  output logic                          out_valid,
  output logic [tsc_pkg::VALUE_W-1:0]   value,
  output logic [tsc_pkg::STATUS_W-1:0]  status
);

  typedef struct packed {
    logic                      tan;
    logic                      neg;
    logic                      czero;
    logic                      big;
    logic [tsc_pkg::MAG_W-1:0] us;
    logic [tsc_pkg::MAG_W-1:0] uc;
    logic [tsc_pkg::MAG_W-1:0] rem;
    logic [tsc_pkg::QB-1:0]    q;
    logic [tsc_pkg::VALUE_W-1:0] val;
  } div_t;

  logic                          vf, vr;
  logic [tsc_pkg::MODE_W-1:0]    fmode;
  logic [tsc_pkg::SUM_W-1:0]     fs, fc;
  logic                          take;
  logic [tsc_pkg::MAG_W-1:0]     us, uc;
  div_t                          prep;
  div_t                          dv  [tsc_pkg::QB+1];
  logic                          dvv [tsc_pkg::QB+1];
  div_t                          dl;
  logic                          over, rnd, r_over, r_neg, r_tan, r_czero;
  logic [tsc_pkg::QB-1:0]        qr, lim, qv;
  logic [tsc_pkg::VALUE_W-1:0]   r_val;
  logic                          sat;
  logic [tsc_pkg::VALUE_W-1:0]   value_next;
  logic [tsc_pkg::STATUS_W-1:0]  status_next;

  // last term into the sums
  always_comb begin
    take = tsc_pkg::COUNT_W'(tsc_pkg::MAX_TERMS - 1) < in_item.n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (en) begin
      vf <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fmode <= in_item.mode;
      fs <= in_item.ln[tsc_pkg::LANE_SIN].sum +
            (take ? tsc_pkg::term_val(in_item.ln[tsc_pkg::LANE_SIN]) : '0);
      fc <= in_item.ln[tsc_pkg::LANE_COS].sum +
            (take ? tsc_pkg::term_val(in_item.ln[tsc_pkg::LANE_COS]) : '0);
    end
  end

  // magnitudes, early overflow test and first partial remainder
  always_comb begin
    us = fs[tsc_pkg::SUM_W-1] ? tsc_pkg::MAG_W'(0) - fs : fs;
    uc = fc[tsc_pkg::SUM_W-1] ? tsc_pkg::MAG_W'(0) - fc : fc;
    prep.tan   = fmode[1];
    prep.neg   = fs[tsc_pkg::SUM_W-1] ^ fc[tsc_pkg::SUM_W-1];
    prep.czero = (fc == '0);
    prep.big   = (us >> tsc_pkg::SHIFT) >= uc;
    prep.us    = us;
    prep.uc    = uc;
    prep.rem   = us >> tsc_pkg::SHIFT;
    prep.q     = '0;
    prep.val   = (fmode == tsc_pkg::MODE_SIN) ? fs : fc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvv[0] <= 1'b0;
    end else if (en) begin
      dvv[0] <= vf;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0] <= prep;
    end
  end

  // restoring division, one quotient bit per stage, msb first
  for (genvar j = 0; j < tsc_pkg::QB; j++) begin : g_bit
    localparam int B = tsc_pkg::QB - 1 - j;
    logic                        nbit;
    logic [tsc_pkg::MAG_W:0]     rem2;
    logic                        ge;
    div_t                        nxt;

    if (B >= tsc_pkg::FRAC_BITS) begin : g_num
      assign nbit = dv[j].us[B - tsc_pkg::FRAC_BITS];
    end else begin : g_zero
      assign nbit = 1'b0;
    end

    always_comb begin
      rem2 = {dv[j].rem, nbit};
      ge   = rem2 >= {1'b0, dv[j].uc};
      nxt  = dv[j];
      nxt.rem = ge ? tsc_pkg::MAG_W'(rem2 - {1'b0, dv[j].uc}) : tsc_pkg::MAG_W'(rem2);
      nxt.q   = {dv[j].q[tsc_pkg::QB-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dvv[j+1] <= 1'b0;
      end else if (en) begin
        dvv[j+1] <= dvv[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[j+1] <= nxt;
      end
    end
  end

  // round to nearest, halves away from zero
  always_comb begin
    dl   = dv[tsc_pkg::QB];
    over = dl.big | (dl.q > {1'b1, {(tsc_pkg::QB-1){1'b0}}});
    rnd  = ~over & ({dl.rem, 1'b0} >= {1'b0, dl.uc});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vr <= 1'b0;
    end else if (en) begin
      vr <= dvv[tsc_pkg::QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qr      <= dl.q + tsc_pkg::QB'(rnd);
      r_over  <= over;
      r_neg   <= dl.neg;
      r_tan   <= dl.tan;
      r_czero <= dl.czero;
      r_val   <= dl.val;
    end
  end

  // saturate, apply sign, pick the result
  always_comb begin
    lim = r_neg ? tsc_pkg::QB'(tsc_pkg::OUT_NEG_MAX) : tsc_pkg::QB'(tsc_pkg::OUT_POS_MAX);
    sat = r_over | (qr > lim);
    qv  = sat ? lim : qr;
    if (!r_tan) begin
      value_next  = r_val;
      status_next = tsc_pkg::ST_OK;
    end else if (r_czero) begin
      value_next  = '0;
      status_next = tsc_pkg::ST_CZERO;
    end else begin
      value_next  = r_neg ? tsc_pkg::VALUE_W'(tsc_pkg::QB'(0) - qv) : tsc_pkg::VALUE_W'(qv);
      status_next = sat ? tsc_pkg::ST_SAT : tsc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value  <= value_next;
      status <= status_next;
    end
  end

endmodule

FILE: rtl/core/taylor_sin_cos_tan_top.sv
// Taylor-series cosine, sine and tangent of a signed Q3.28 angle (tuser selects cosine,
// sine or tangent; mode three acts as tangent). term_count (reset 11, capped at 11) sets
// how many terms are summed. One word is accepted per clock while the skid word is
// empty. Stages in order: angle squaring, 10 term recurrence steps (four 32-bit-class
// multiplies per step and lane), the final sums, the bit-per-stage tangent divider,
// rounding and saturation, and the output register. A two-word output buffer (output
// register and skid word) lets input flow until the skid word fills; then the whole
// pipeline holds. Result status: 0 ok, 1 tangent saturated, 2 cosine sum zero (value 0).
module taylor_sin_cos_tan_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [tsc_pkg::ANGLE_W-1:0]   s_tdata,   // angle
  input  logic [tsc_pkg::MODE_W-1:0]    s_tuser,   // mode
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [tsc_pkg::VALUE_W-1:0]   m_tdata,   // value
  output logic [tsc_pkg::STATUS_W-1:0]  m_tuser,   // status
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tsc_pkg::COUNT_W-1:0]   cfg_data
);

  logic                          en;
  logic [tsc_pkg::COUNT_W-1:0]   term_count;
  logic                          chain_v    [tsc_pkg::MAX_TERMS];
  tsc_pkg::item_t                chain_item [tsc_pkg::MAX_TERMS];
  logic                          div_valid;
  logic [tsc_pkg::VALUE_W-1:0]   div_value;
  logic [tsc_pkg::STATUS_W-1:0]  div_status;
  logic                          skid_valid;
  logic [tsc_pkg::VALUE_W-1:0]   skid_value;
  logic [tsc_pkg::STATUS_W-1:0]  skid_status;
  logic                          push;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_count <= tsc_pkg::TERM_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      term_count <= cfg_data;
    end
  end

  // pipeline advances unless the skid word is occupied
  assign en       = ~skid_valid;
  assign s_tready = en;

  tsc_square u_square (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (s_tvalid & s_tready),
    .mode       (s_tuser),
    .angle      (s_tdata),
    .term_count (term_count),
    .out_valid  (chain_v[0]),
    .out_item   (chain_item[0])
  );

  // term recurrence steps
  for (genvar g = 1; g < tsc_pkg::MAX_TERMS; g++) begin : g_step
    tsc_step u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .step      (tsc_pkg::COUNT_W'(g)),
      .in_valid  (chain_v[g-1]),
      .in_item   (chain_item[g-1]),
      .out_valid (chain_v[g]),
      .out_item  (chain_item[g])
    );
  end

  tsc_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (chain_v[tsc_pkg::MAX_TERMS-1]),
    .in_item   (chain_item[tsc_pkg::MAX_TERMS-1]),
    .out_valid (div_valid),
    .value     (div_value),
    .status    (div_status)
  );

  // output register with skid word
  assign push = div_valid & en;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tdata <= skid_value;
        m_tuser <= skid_status;
      end else if (push) begin
        m_tdata <= div_value;
        m_tuser <= div_status;
      end
    end else if (push) begin
      skid_value  <= div_value;
      skid_status <= div_status;
    end
  end

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid word held without an output word");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready && div_valid && en) |=> skid_valid)
    else $error("result dropped during output stall");

  a_czero_value: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == tsc_pkg::ST_CZERO) |-> (m_tdata == '0))
    else $error("zero cosine result carries a nonzero value");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == tsc_pkg::ST_SAT) |->
    (m_tdata == tsc_pkg::OUT_POS_MAX || m_tdata == tsc_pkg::OUT_NEG_MAX))
    else $error("saturated tangent not at a range limit");

endmodule

FILE: dv/taylor_sin_cos_tan_top_test.sv
`timescale 1ns / 100ps

module taylor_sin_cos_tan_top_test;

  localparam longint LIM62 = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam longint ANG_MAX = 1686629713;
  localparam int LATENCY = 97;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [tsc_pkg::VALUE_W-1:0]  value;
    logic [tsc_pkg::STATUS_W-1:0] status;
  } trig_result_t;

  typedef struct {
    logic [tsc_pkg::MODE_W-1:0]   mode;
    logic [tsc_pkg::ANGLE_W-1:0]  angle;
    bit                           typed;
    logic [tsc_pkg::VALUE_W-1:0]  value;
    logic [tsc_pkg::STATUS_W-1:0] status;
  } stim_row_t;

  logic clk, rst;
  logic s_tvalid, s_tready;
  logic [tsc_pkg::ANGLE_W-1:0] s_tdata;
  logic [tsc_pkg::MODE_W-1:0] s_tuser;
  logic m_tvalid, m_tready;
  logic [tsc_pkg::VALUE_W-1:0] m_tdata;
  logic [tsc_pkg::STATUS_W-1:0] m_tuser;
  logic cfg_valid, cfg_ready;
  logic [tsc_pkg::COUNT_W-1:0] cfg_data;

  trig_result_t pending_q[$];
  logic [tsc_pkg::COUNT_W-1:0] terms_shadow;
  int errors = 0;
  int tx_idle_pct = 0, rx_idle_pct = 0;
  bit rx_hold = 0;
  int results_seen = 0, items_sent = 0;
  longint cycles = 0;

  taylor_sin_cos_tan_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // cycle watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // fixed-point helpers
  function automatic logic [63:0] mag64(longint v);
    return v < 0 ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  function automatic longint fx_mult(longint a, longint b);
    logic [127:0] p;
    logic [63:0] m;
    p = {64'd0, mag64(a)} * {64'd0, mag64(b)} + (128'd1 << (tsc_pkg::FRAC_BITS - 1));
    if ((p >> (64 + tsc_pkg::FRAC_BITS)) != 0) m = LIM62;
    else m = 64'(p >> tsc_pkg::FRAC_BITS);
    if (m > LIM62) m = LIM62;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint sat_add(longint a, longint b);
    longint s;
    s = a + b;
    if (s > LIM62) s = LIM62;
    if (s < -LIM62) s = -LIM62;
    return s;
  endfunction

  function automatic longint taylor_sum(longint x, longint x2, int n, int odd);
    longint term, sum, d, r;
    term = odd ? x : (longint'(1) << tsc_pkg::FRAC_BITS);
    sum = 0;
    for (int i = 0; i < n; i++) begin
      if (i > 0) begin
        d = (2 * i + odd - 1) * (2 * i + odd);
        r = ((longint'(1) << tsc_pkg::FRAC_BITS) + d / 2) / d;
        term = -fx_mult(fx_mult(term, x2), r);
      end
      sum = sat_add(sum, term);
    end
    return sum;
  endfunction

  function automatic logic [tsc_pkg::VALUE_W-1:0] clamp48(longint v);
    if (v > longint'(tsc_pkg::OUT_POS_MAX)) v = longint'(tsc_pkg::OUT_POS_MAX);
    if (v < -longint'({16'd0, tsc_pkg::OUT_NEG_MAX}))
      v = -longint'({16'd0, tsc_pkg::OUT_NEG_MAX});
    return v[tsc_pkg::VALUE_W-1:0];
  endfunction

  function automatic trig_result_t predict_trig(logic [tsc_pkg::MODE_W-1:0] mode,
                                                logic [tsc_pkg::ANGLE_W-1:0] angle,
                                                logic [tsc_pkg::COUNT_W-1:0] terms);
    trig_result_t r;
    longint x, x2, s, c;
    logic [127:0] num, q, rm;
    logic [63:0] us, uc, lim;
    int n;
    bit neg;
    x = longint'(signed'(angle));
    n = terms > tsc_pkg::MAX_TERMS ? tsc_pkg::MAX_TERMS : terms;
    x2 = fx_mult(x, x);
    r.status = tsc_pkg::ST_OK;
    if (mode[1] == 1'b0) begin
      r.value = clamp48(taylor_sum(x, x2, n, mode[0]));
    end else begin
      s = taylor_sum(x, x2, n, 1);
      c = taylor_sum(x, x2, n, 0);
      if (c == 0) begin
        r.value = '0;
        r.status = tsc_pkg::ST_CZERO;
      end else begin
        us = mag64(s);
        uc = mag64(c);
        neg = (s < 0) != (c < 0);
        num = {64'd0, us} << tsc_pkg::FRAC_BITS;
        q = num / uc;
        rm = num % uc;
        lim = neg ? {16'd0, tsc_pkg::OUT_NEG_MAX} : {16'd0, tsc_pkg::OUT_POS_MAX};
        if (q > ({64'd0, 16'd0, tsc_pkg::OUT_NEG_MAX} * 2)) begin
          q = lim;
          r.status = tsc_pkg::ST_SAT;
        end else begin
          if (rm >= uc - rm) q = q + 1;
          if (q > lim) begin
            q = lim;
            r.status = tsc_pkg::ST_SAT;
          end
        end
        r.value = neg ? tsc_pkg::VALUE_W'(48'd0 - q[47:0]) : q[tsc_pkg::VALUE_W-1:0];
      end
    end
    return r;
  endfunction

  // result checker and receiver ready
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      trig_result_t exp_r;
      results_seen <= results_seen + 1;
      if (pending_q.size() == 0) begin
        $error("unexpected result value=%h status=%0d", m_tdata, m_tuser);
        errors <= errors + 1;
      end else begin
        exp_r = pending_q.pop_front();
        if (m_tdata !== exp_r.value) begin
          $error("value: expected %h, got %h", exp_r.value, m_tdata);
          errors <= errors + 1;
        end
        if (m_tuser !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, m_tuser);
          errors <= errors + 1;
        end
      end
    end
    if (rst) m_tready <= 1'b0;
    else m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic write_terms(logic [tsc_pkg::COUNT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    terms_shadow = val;
  endtask

  // send one word, queue its expectation at acceptance; valid stays up for the next word
  task automatic send_angle(logic [tsc_pkg::MODE_W-1:0] mode,
                            logic [tsc_pkg::ANGLE_W-1:0] angle,
                            bit typed, trig_result_t typed_r);
    trig_result_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= angle;
    s_tuser <= mode;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = typed ? typed_r : predict_trig(mode, angle, terms_shadow);
    pending_q.push_back(r);
    items_sent++;
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [tsc_pkg::ANGLE_W-1:0] rand_angle();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return $urandom();
    if (sel == 1) return tsc_pkg::ANGLE_W'(ANG_MAX);
    if (sel < 4) return tsc_pkg::ANGLE_W'($urandom_range(4000));
    return tsc_pkg::ANGLE_W'(longint'($urandom_range(2 * ANG_MAX)) - ANG_MAX);
  endfunction

  stim_row_t dir_rows[$];

  task automatic add_row(logic [tsc_pkg::MODE_W-1:0] m, logic [tsc_pkg::ANGLE_W-1:0] a,
                         bit t, logic [tsc_pkg::VALUE_W-1:0] v,
                         logic [tsc_pkg::STATUS_W-1:0] st);
    stim_row_t row;
    row.mode = m; row.angle = a; row.typed = t; row.value = v; row.status = st;
    dir_rows.push_back(row);
  endtask

  initial begin
    trig_result_t tr;
    logic [tsc_pkg::COUNT_W-1:0] counts[6] = '{4'd11, 4'd1, 4'd15, 4'd0, 4'd5, 4'd11};
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
    cfg_valid = 1'b0; cfg_data = '0;
    terms_shadow = tsc_pkg::TERM_COUNT_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: zero angle, extremes, all modes, mode three
    add_row(tsc_pkg::MODE_COS, '0, 1, tsc_pkg::VALUE_W'(tsc_pkg::ONE), tsc_pkg::ST_OK);
    add_row(tsc_pkg::MODE_SIN, '0, 1, '0, tsc_pkg::ST_OK);
    add_row(tsc_pkg::MODE_TAN, '0, 1, '0, tsc_pkg::ST_OK);
    add_row(tsc_pkg::MODE_TAN_ALT, '0, 1, '0, tsc_pkg::ST_OK);
    add_row(tsc_pkg::MODE_COS, tsc_pkg::ANGLE_W'(ANG_MAX), 0, '0, tsc_pkg::ST_OK);
    add_row(tsc_pkg::MODE_SIN, tsc_pkg::ANGLE_W'(-ANG_MAX), 0, '0, tsc_pkg::ST_OK);
    add_row(tsc_pkg::MODE_TAN, tsc_pkg::ANGLE_W'(421657428), 0, '0, tsc_pkg::ST_OK);
    add_row(tsc_pkg::MODE_TAN, tsc_pkg::ANGLE_W'(-421657428), 0, '0, tsc_pkg::ST_OK);
    add_row(tsc_pkg::MODE_TAN_ALT, tsc_pkg::ANGLE_W'(ANG_MAX), 0, '0, tsc_pkg::ST_OK);
    add_row(tsc_pkg::MODE_COS, 32'h7FFF_FFFF, 0, '0, tsc_pkg::ST_OK);
    add_row(tsc_pkg::MODE_SIN, 32'h8000_0000, 0, '0, tsc_pkg::ST_OK);
    add_row(tsc_pkg::MODE_TAN, 32'hFFFF_FFFF, 0, '0, tsc_pkg::ST_OK);
    add_row(tsc_pkg::MODE_TAN, tsc_pkg::ANGLE_W'(843314857), 0, '0, tsc_pkg::ST_OK);
    foreach (dir_rows[i]) begin
      tr.value = dir_rows[i].value;
      tr.status = dir_rows[i].status;
      send_angle(dir_rows[i].mode, dir_rows[i].angle, dir_rows[i].typed, tr);
    end
    drain();

    // zero terms: tangent sees a zero cosine sum
    write_terms(4'd0);
    tr.value = '0; tr.status = tsc_pkg::ST_CZERO;
    send_angle(tsc_pkg::MODE_TAN, tsc_pkg::ANGLE_W'(ANG_MAX), 1, tr);
    tr.status = tsc_pkg::ST_OK;
    send_angle(tsc_pkg::MODE_SIN, tsc_pkg::ANGLE_W'(ANG_MAX), 1, tr);
    drain();

    // random phases across term counts and idle profiles
    for (int ph = 0; ph < 6; ph++) begin
      write_terms(counts[ph]);
      if (ph < 2) begin tx_idle_pct = 28; rx_idle_pct = 45; end
      else if (ph < 4) begin tx_idle_pct = 45; rx_idle_pct = 28; end
      else begin tx_idle_pct = 0; rx_idle_pct = 0; end
      if (ph == 2) begin
        // long receiver stall while the sender keeps pushing
        fork
          begin
            rx_hold = 1;
            repeat (300) @(posedge clk);
            rx_hold = 0;
          end
          for (int i = 0; i < 120; i++)
            send_angle(2'($urandom_range(3)), rand_angle(), 0, tr);
        join
      end
      for (int i = 0; i < 90; i++)
        send_angle(2'($urandom_range(3)), rand_angle(), 0, tr);
      drain();
    end

    $display("sent %0d words, checked %0d results over term counts 0..15 and all modes",
             items_sent, results_seen);
    if (errors == 0 && pending_q.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
